// ----- rtl/core/tccw_pkg.sv -----
// ---------------------------------------------------------------------------
// tccw_pkg: shared types and constants for the text console cursor writer
// Screen geometry, character codes, result kinds and the record types that
// pass between the sequencer, the position unit and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STOP = 8;

	localparam int COL_W  = $clog2(COLUMNS + 1);
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int POS_W  = 11;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;

	localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] BLANK_GLYPH  = 8'd32;
	localparam logic [ATTR_W-1:0] CELL_ATTR    = 8'd7;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_CURSOR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRAP,
		S_TAB,
		S_PUT,
		S_EOT
	} seq_state_t;

	typedef struct packed {
		kind_t              kind;
		logic [POS_W-1:0]   position;
		logic [CHAR_W-1:0]  glyph;
		logic [ATTR_W-1:0]  attribute;
		logic               last;
	} result_t;

	typedef struct packed {
		logic             advance_row;
		logic [COL_W-1:0] column;
	} pos_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/text_console_cursor_writer.sv -----
// ---------------------------------------------------------------------------
// text_console_cursor_writer: screen command generator for a text console
// Turns a stream of character codes into cell writes, scroll commands and
// cursor reports for an 80 by 25 text screen.
// ---------------------------------------------------------------------------
// Flow: an accepted item is held in the sequencer, which takes no new item
//   until it has emitted all of that item's results; a line wrap that does
//   not scroll first passes through the wrap state, which emits nothing. The
//   sequencer steps one result per cycle, when the output register can take
//   it, through a single position adder.
// Reset: arst_n clears the cursor to row 0, column 0 and empties the output.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_writer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // end_of_text
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [10:0] position, [18:11] glyph,
	                                    // [26:19] attribute, [31:27] zero
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast    // last
);

	logic                            emit_valid;
	logic                            emit_ready;
	tccw_pkg::result_t               emit;
	tccw_pkg::pos_ctl_t              pos_ctl;
	logic [tccw_pkg::POS_W-1:0]      position;

	logic                            out_valid_q;
	tccw_pkg::result_t               out_q;

	// sequencer: one result per cycle when the output register can take it, cursor state lives here
	tccw_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_char    (s_tdata),
		.in_eot     (s_tlast),
		.emit_valid (emit_valid),
		.emit_ready (emit_ready),
		.emit       (emit),
		.pos_ctl    (pos_ctl),
		.position   (position)
	);

	// shared position adder with the row base
	tccw_pos_unit u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pos_ctl),
		.position (position)
	);

	// output register: load when empty or being drained, else hold
	assign emit_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_ready) begin
			out_valid_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid && emit_ready) begin
			out_q <= emit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {5'd0, out_q.attribute, out_q.glyph, out_q.position};

endmodule

`default_nettype wire

// ----- rtl/core/tccw_pos_unit.sv -----
// ---------------------------------------------------------------------------
// tccw_pos_unit: cell index unit
// Holds the base index of the cursor row and forms base + column with one
// shared adder; every write and cursor result takes its position from here.
// ---------------------------------------------------------------------------
`default_nettype none

module tccw_pos_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tccw_pkg::pos_ctl_t         ctl,
	output logic [tccw_pkg::POS_W-1:0]      position
);

	logic [tccw_pkg::POS_W-1:0] base_q;

	// advance the row base by one screen line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (ctl.advance_row) begin
			base_q <= base_q + tccw_pkg::POS_W'(tccw_pkg::COLUMNS);
		end
	end

	assign position = base_q + tccw_pkg::POS_W'(ctl.column);

endmodule

`default_nettype wire

// ----- rtl/core/tccw_seq.sv -----
// ---------------------------------------------------------------------------
// tccw_seq: character sequencer
// Steps one character through wrap, tab expansion, cell write and cursor
// report, one result per cycle when not stalled, and keeps the cursor column and row.
// ---------------------------------------------------------------------------
`default_nettype none

module tccw_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [tccw_pkg::CHAR_W-1:0]   in_char,
	input  wire logic                          in_eot,
	output logic                               emit_valid,
	input  wire logic                          emit_ready,
	output tccw_pkg::result_t                  emit,
	output tccw_pkg::pos_ctl_t                 pos_ctl,
	input  wire logic [tccw_pkg::POS_W-1:0]    position
);

	localparam int COL_W = tccw_pkg::COL_W;
	localparam int ROW_W = tccw_pkg::ROW_W;

	tccw_pkg::seq_state_t state_q, state_d;

	logic [COL_W-1:0]            col_q, col_d;
	logic [ROW_W-1:0]            row_q, row_d;
	logic [COL_W-1:0]            tab_end_q, tab_end_d;
	logic [tccw_pkg::CHAR_W-1:0] char_q;
	logic                        eot_q;
	logic                        accept;
	logic                        is_newline;
	logic [COL_W:0]              tab_raw;
	logic [COL_W-1:0]            col_inc;

	assign accept     = in_valid && in_ready;
	assign is_newline = (char_q == tccw_pkg::CHAR_NEWLINE);
	assign col_inc    = col_q + COL_W'(1);
	assign tab_raw    = (COL_W+1)'((int'(col_q) / tccw_pkg::TAB_STOP + 1) * tccw_pkg::TAB_STOP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tccw_pkg::S_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
		end
	end

	// hold the item and its tab stop
	always_ff @(posedge clk) begin
		tab_end_q <= tab_end_d;
		if (accept) begin
			char_q <= in_char;
			eot_q  <= in_eot;
		end
	end

	always_comb begin
		state_d             = state_q;
		col_d               = col_q;
		row_d               = row_q;
		tab_end_d           = tab_end_q;
		in_ready            = 1'b0;
		emit_valid          = 1'b0;
		emit.kind           = tccw_pkg::KIND_WRITE;
		emit.position       = position;
		emit.glyph          = char_q;
		emit.attribute      = tccw_pkg::CELL_ATTR;
		emit.last           = !eot_q;
		pos_ctl.advance_row = 1'b0;
		pos_ctl.column      = col_q;
		case (state_q)
			tccw_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (tab_raw > (COL_W+1)'(tccw_pkg::COLUMNS)) begin
					tab_end_d = COL_W'(tccw_pkg::COLUMNS);
				end else begin
					tab_end_d = tab_raw[COL_W-1:0];
				end
				if (in_valid) begin
					if (in_char == tccw_pkg::CHAR_NEWLINE
					    || col_q >= COL_W'(tccw_pkg::COLUMNS)) begin
						state_d = tccw_pkg::S_WRAP;
					end else if (in_char == tccw_pkg::CHAR_TAB) begin
						state_d = tccw_pkg::S_TAB;
					end else begin
						state_d = tccw_pkg::S_PUT;
					end
				end
			end
			tccw_pkg::S_WRAP: begin
				// bottom row: scroll and keep the row; else step down a row
				if (row_q == ROW_W'(tccw_pkg::ROWS - 1)) begin
					emit_valid     = 1'b1;
					emit.kind      = tccw_pkg::KIND_SCROLL;
					emit.position  = '0;
					emit.glyph     = tccw_pkg::BLANK_GLYPH;
					emit.last      = is_newline && !eot_q;
				end
				if (!emit_valid || emit_ready) begin
					col_d = '0;
					if (!emit_valid) begin
						row_d               = row_q + ROW_W'(1);
						pos_ctl.advance_row = 1'b1;
					end
					if (!is_newline) begin
						state_d = tccw_pkg::S_PUT;
					end else if (eot_q) begin
						state_d = tccw_pkg::S_EOT;
					end else begin
						state_d = tccw_pkg::S_IDLE;
					end
				end
			end
			tccw_pkg::S_TAB: begin
				emit_valid = 1'b1;
				emit.glyph = tccw_pkg::BLANK_GLYPH;
				emit.last  = (col_inc == tab_end_q) && !eot_q;
				if (emit_ready) begin
					col_d = col_inc;
					if (col_inc == tab_end_q) begin
						state_d = eot_q ? tccw_pkg::S_EOT : tccw_pkg::S_IDLE;
					end
				end
			end
			tccw_pkg::S_PUT: begin
				emit_valid = 1'b1;
				if (emit_ready) begin
					col_d   = col_inc;
					state_d = eot_q ? tccw_pkg::S_EOT : tccw_pkg::S_IDLE;
				end
			end
			tccw_pkg::S_EOT: begin
				emit_valid     = 1'b1;
				emit.kind      = tccw_pkg::KIND_CURSOR;
				emit.glyph     = '0;
				emit.attribute = '0;
				emit.last      = 1'b1;
				if (emit_ready) begin
					state_d = tccw_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tccw_pkg::S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_W'(tccw_pkg::COLUMNS))
		else $error("cursor column beyond row end");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_W'(tccw_pkg::ROWS - 1))
		else $error("cursor row beyond last row");
	a_tab_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tccw_pkg::S_TAB |-> col_q < tab_end_q)
		else $error("tab expansion ran past its stop");
	a_cursor_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && emit.kind == tccw_pkg::KIND_CURSOR |-> emit.last)
		else $error("cursor result not marked last");
`endif

endmodule

`default_nettype wire
